[src/etwa_pkg.sv]
// Package for the edge time window averager: ring size, field widths, codes.
`default_nettype none
package etwa_pkg;

  localparam int RING_DEPTH = 16;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  localparam int STAMP_W    = 32;
  localparam int HELD_W     = 5;
  localparam int FRAC_W     = 8;
  localparam int AVG_W      = STAMP_W + FRAC_W;
  localparam int DIV_CNT_W  = $clog2(AVG_W + 1);

  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_EXPIRE = 1'b1;

  // Word index of a configuration register (paddr[2]).
  localparam logic REG_EXPIRE_WINDOW = 1'b0;

  localparam logic [STAMP_W-1:0] EXPIRE_RESET = STAMP_W'(100);

endpackage
`default_nettype wire

[src/edge_time_window_averager_unit.sv]
// Top level of the edge time window averager: timestamp ring, expiry walk and serial divider.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+-------------------------------------------
//  input     | in_valid / in_ready      | command, sample_time
//  result    | out_valid / out_ready    | held_count, expired_count, avg_edge_ticks
//  config    | APB psel/penable/pwrite  | paddr, pwdata, prdata, pready (always high)
//
// A record item passes through the ring write, the two span states, the serial divider
// and the done state before in_ready returns; an expire item walks the ring instead of
// writing, reading and comparing each entry it examines. Under two entries held, the
// divider and the second span state are skipped.
// rst is synchronous and empties the ring; in_ready is high only while the sequencer is idle.
// A waiting result stalls the next one in its final state but does not hold in_ready low.
`default_nettype none
module edge_time_window_averager_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              command,
  input  wire logic [etwa_pkg::STAMP_W-1:0]      sample_time,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [etwa_pkg::HELD_W-1:0]            held_count,
  output logic [etwa_pkg::HELD_W-1:0]            expired_count,
  output logic [etwa_pkg::AVG_W-1:0]             avg_edge_ticks,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [etwa_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [etwa_pkg::PDATA_W-1:0]      pwdata,
  output logic [etwa_pkg::PDATA_W-1:0]           prdata,
  output logic                                   pready
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_WRITE   = 8'b0000_0010,
    S_EXP_RD  = 8'b0000_0100,
    S_EXP_CMP = 8'b0000_1000,
    S_SPAN_A  = 8'b0001_0000,
    S_SPAN_B  = 8'b0010_0000,
    S_DIV     = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t state;

  logic [etwa_pkg::STAMP_W-1:0] ring [etwa_pkg::RING_DEPTH];
  logic [etwa_pkg::STAMP_W-1:0] rdata;
  logic [etwa_pkg::SLOT_W-1:0]  raddr;
  logic [etwa_pkg::SLOT_W-1:0]  waddr;
  logic                         wen;

  logic [etwa_pkg::SLOT_W-1:0]  oldest_slot;
  logic [etwa_pkg::CNT_W-1:0]   entry_total;
  logic [etwa_pkg::CNT_W-1:0]   expired;
  logic [etwa_pkg::STAMP_W-1:0] expire_window;
  logic                         cmd;
  logic [etwa_pkg::STAMP_W-1:0] stamp;
  logic [etwa_pkg::STAMP_W-1:0] first;
  logic [etwa_pkg::CNT_W-1:0]   rem;
  logic [etwa_pkg::AVG_W-1:0]   dq;
  logic [etwa_pkg::DIV_CNT_W-1:0] div_left;

  logic                         full;
  logic [etwa_pkg::SLOT_W-1:0]  oldest_inc;
  logic [etwa_pkg::SLOT_W:0]    tail_sum;
  logic [etwa_pkg::SLOT_W-1:0]  tail_slot;
  logic [etwa_pkg::SLOT_W:0]    newest_sum;
  logic [etwa_pkg::SLOT_W-1:0]  newest_slot;
  logic [etwa_pkg::STAMP_W:0]   limit;
  logic                         expire_hit;
  logic [etwa_pkg::CNT_W:0]     trial;
  logic                         trial_ge;
  logic [etwa_pkg::CNT_W:0]     trial_diff;
  logic                         cfg_write;

  assign in_ready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == etwa_pkg::REG_EXPIRE_WINDOW);
  assign prdata   = (paddr[2] == etwa_pkg::REG_EXPIRE_WINDOW) ? expire_window : '0;

  assign full = (entry_total == etwa_pkg::CNT_W'(etwa_pkg::RING_DEPTH));
  assign oldest_inc = (oldest_slot == etwa_pkg::SLOT_W'(etwa_pkg::RING_DEPTH - 1)) ?
                      '0 : oldest_slot + 1'b1;

  // Slot past the newest entry; only used while the ring is not full.
  always_comb begin
    tail_sum = {1'b0, oldest_slot} + (etwa_pkg::SLOT_W + 1)'(entry_total);
    if (tail_sum >= (etwa_pkg::SLOT_W + 1)'(etwa_pkg::RING_DEPTH)) begin
      tail_sum = tail_sum - (etwa_pkg::SLOT_W + 1)'(etwa_pkg::RING_DEPTH);
    end
    tail_slot = tail_sum[etwa_pkg::SLOT_W-1:0];
  end

  // Slot of the newest entry; only used with at least one entry held.
  always_comb begin
    newest_sum = {1'b0, oldest_slot} + (etwa_pkg::SLOT_W + 1)'(entry_total - 1'b1);
    if (newest_sum >= (etwa_pkg::SLOT_W + 1)'(etwa_pkg::RING_DEPTH)) begin
      newest_sum = newest_sum - (etwa_pkg::SLOT_W + 1)'(etwa_pkg::RING_DEPTH);
    end
    newest_slot = newest_sum[etwa_pkg::SLOT_W-1:0];
  end

  // The window sum is kept at 33 bits so it never wraps.
  assign limit      = {1'b0, rdata} + {1'b0, expire_window};
  assign expire_hit = ({1'b0, stamp} > limit);

  // One restoring divide step per cycle; the remainder stays below the divisor.
  assign trial      = {rem, dq[etwa_pkg::AVG_W-1]};
  assign trial_ge   = (trial >= {1'b0, entry_total});
  assign trial_diff = trial - {1'b0, entry_total};

  // A record into a full ring overwrites the oldest slot, so the next oldest is read instead.
  assign raddr = (state == S_SPAN_A) ? newest_slot :
                 ((state == S_WRITE) && full) ? oldest_inc : oldest_slot;
  assign wen   = (state == S_WRITE);
  assign waddr = full ? oldest_slot : tail_slot;

  always_ff @(posedge clk) begin
    if (wen) begin
      ring[waddr] <= stamp;
    end
    rdata <= ring[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expire_window <= etwa_pkg::EXPIRE_RESET;
    end else if (cfg_write) begin
      expire_window <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      oldest_slot <= '0;
      entry_total <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd     <= command;
            stamp   <= sample_time;
            expired <= '0;
            state   <= (command == etwa_pkg::CMD_RECORD) ? S_WRITE : S_EXP_RD;
          end
        end
        S_WRITE: begin
          // A full ring drops its oldest entry and reuses that slot.
          if (full) begin
            oldest_slot <= oldest_inc;
          end else begin
            entry_total <= entry_total + 1'b1;
          end
          state <= S_SPAN_A;
        end
        S_EXP_RD: begin
          state <= (entry_total == '0) ? S_SPAN_A : S_EXP_CMP;
        end
        S_EXP_CMP: begin
          if (expire_hit) begin
            oldest_slot <= oldest_inc;
            entry_total <= entry_total - 1'b1;
            expired     <= expired + 1'b1;
            state       <= S_EXP_RD;
          end else begin
            state <= S_SPAN_A;
          end
        end
        S_SPAN_A: begin
          // rdata holds the oldest entry here; the newest is read next.
          first <= rdata;
          if (entry_total < etwa_pkg::CNT_W'(2)) begin
            dq    <= '0;
            state <= S_DONE;
          end else begin
            state <= S_SPAN_B;
          end
        end
        S_SPAN_B: begin
          dq       <= {rdata - first, etwa_pkg::FRAC_W'(0)};
          rem      <= '0;
          div_left <= etwa_pkg::DIV_CNT_W'(etwa_pkg::AVG_W);
          state    <= S_DIV;
        end
        S_DIV: begin
          rem      <= trial_ge ? trial_diff[etwa_pkg::CNT_W-1:0] : trial[etwa_pkg::CNT_W-1:0];
          dq       <= {dq[etwa_pkg::AVG_W-2:0], trial_ge};
          div_left <= div_left - 1'b1;
          if (div_left == etwa_pkg::DIV_CNT_W'(1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            held_count     <= etwa_pkg::HELD_W'(entry_total);
            expired_count  <= (cmd == etwa_pkg::CMD_EXPIRE) ? etwa_pkg::HELD_W'(expired) : '0;
            avg_edge_ticks <= dq;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    entry_total <= etwa_pkg::CNT_W'(etwa_pkg::RING_DEPTH))
    else $error("entry count above ring depth");

  a_expire_drop: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXP_CMP && expire_hit) |=>
      (entry_total == $past(entry_total) - 1'b1 && state == S_EXP_RD))
    else $error("expiry did not drop exactly one entry");

  a_record_grow: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && !full) |=> (entry_total == $past(entry_total) + 1'b1))
    else $error("record into a ring with room did not grow the count");

  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_left == etwa_pkg::DIV_CNT_W'(1)) |=> (state == S_DONE))
    else $error("divider did not finish after its last step");
`endif

endmodule
`default_nettype wire
